// ===== rtl/ddft_pkg.sv =====
package ddft_pkg;

    // default transform length and fixed field widths
    localparam int MAX_POINTS_DEF = 64;
    localparam int SAMPLE_W       = 16;
    localparam int TW_W           = 32;
    localparam int PROD_W         = 64;
    localparam int SPROD_W        = SAMPLE_W + TW_W;
    localparam int ACC_W          = 64;
    localparam int OUT_W          = 23;
    localparam int Q_FRAC         = 30;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic signed [PROD_W-1:0] Q_ONE64  = 64'sd1 <<< Q_FRAC;
    localparam logic signed [PROD_W-1:0] Q_HALF64 = 64'sd1 <<< (Q_FRAC - 1);
    localparam logic signed [TW_W-1:0]   Q_ONE    = 32'sd1 <<< Q_FRAC;
    localparam logic signed [PROD_W-1:0] OUT_MAX64 = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [PROD_W-1:0] OUT_MIN64 = -(64'sd1 <<< (OUT_W - 1));

    // register index codes
    typedef enum logic {
        REG_ROOT_REAL = 1'b0,
        REG_ROOT_IMAG = 1'b1
    } reg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_BMUL,
        ST_BADD
    } state_t;

    // controls shared by every sample cell
    typedef struct packed {
        logic write_en;
        logic rotate_en;
    } cell_ctrl_t;

    // controls for the accumulator pair
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic add_en;
    } acc_ctrl_t;

    // clamp a wide value to the twiddle range [-1.0, 1.0]
    function automatic logic signed [TW_W-1:0] clamp_q(input logic signed [PROD_W-1:0] v);
        logic signed [TW_W-1:0] r;
        if (v > Q_ONE64)
            r = Q_ONE;
        else if (v < -Q_ONE64)
            r = -Q_ONE;
        else
            r = v[TW_W-1:0];
        return r;
    endfunction

    // round half up, drop the fraction and saturate to the output width
    function automatic logic signed [OUT_W-1:0] finish_acc(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        logic signed [OUT_W-1:0] r;
        v = (acc + Q_HALF64) >>> Q_FRAC;
        if (v > OUT_MAX64)
            r = OUT_MAX64[OUT_W-1:0];
        else if (v < OUT_MIN64)
            r = OUT_MIN64[OUT_W-1:0];
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/ddft_cell.sv =====
module ddft_cell
    import ddft_pkg::*;
(
    input  logic                       clk,
    input  cell_ctrl_t                 ctrl,
    input  logic                       sel,
    input  logic                       wrap,
    input  logic signed [SAMPLE_W-1:0] din_new,
    input  logic signed [SAMPLE_W-1:0] din_next,
    input  logic signed [SAMPLE_W-1:0] din_head,
    output logic signed [SAMPLE_W-1:0] dout
);

    logic signed [SAMPLE_W-1:0] q_reg;
    logic signed [SAMPLE_W-1:0] q_next;

    // load a new beat, or pass the neighbor's value toward the head
    always_comb
    begin
        q_next = q_reg;
        if (ctrl.write_en && sel)
            q_next = din_new;
        else if (ctrl.rotate_en)
            q_next = wrap ? din_head : din_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign dout = q_reg;

endmodule

// ===== rtl/ddft_cmul.sv =====
module ddft_cmul
    import ddft_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [TW_W-1:0] a_re,
    input  logic signed [TW_W-1:0] a_im,
    input  logic signed [TW_W-1:0] b_re,
    input  logic signed [TW_W-1:0] b_im,
    output logic signed [TW_W-1:0] p_re,
    output logic signed [TW_W-1:0] p_im
);

    logic signed [PROD_W-1:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [PROD_W-1:0] rr_next, ii_next, ri_next, ir_next;
    logic signed [PROD_W-1:0] sum_re, sum_im;

    // partial products
    always_comb
    begin
        rr_next = a_re * b_re;
        ii_next = a_im * b_im;
        ri_next = a_re * b_im;
        ir_next = a_im * b_re;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg <= rr_next;
            ii_reg <= ii_next;
            ri_reg <= ri_next;
            ir_reg <= ir_next;
        end
    end

    // combine, round half up, shift and clamp
    always_comb
    begin
        sum_re = rr_reg - ii_reg + Q_HALF64;
        sum_im = ri_reg + ir_reg + Q_HALF64;
        p_re   = clamp_q(sum_re >>> Q_FRAC);
        p_im   = clamp_q(sum_im >>> Q_FRAC);
    end

endmodule

// ===== rtl/ddft_acc.sv =====
module ddft_acc
    import ddft_pkg::*;
(
    input  logic                       clk,
    input  acc_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [TW_W-1:0]     tw_re,
    input  logic signed [TW_W-1:0]     tw_im,
    output logic signed [OUT_W-1:0]    fin_re,
    output logic signed [OUT_W-1:0]    fin_im
);

    logic signed [SPROD_W-1:0] sp_re_reg, sp_im_reg;
    logic signed [SPROD_W-1:0] sp_re_next, sp_im_next;
    logic signed [ACC_W-1:0]   acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]   acc_re_next, acc_im_next;

    // sample times twiddle
    always_comb
    begin
        sp_re_next = sample * tw_re;
        sp_im_next = sample * tw_im;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            sp_re_reg <= sp_re_next;
            sp_im_reg <= sp_im_next;
        end
    end

    // running sums
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (ctrl.clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (ctrl.add_en)
        begin
            acc_re_next = acc_re_reg + ACC_W'(sp_re_reg);
            acc_im_next = acc_im_reg + ACC_W'(sp_im_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    assign fin_re = finish_acc(acc_re_reg);
    assign fin_im = finish_acc(acc_im_reg);

endmodule

// ===== rtl/direct_dft_real_input_core.sv =====
// Direct DFT of a block of real Q1.15 samples. Samples are taken one per start
// beat into a row of sample cells until a beat with last_sample set, or until
// MAX_POINTS are held; that block has N points and busy rises. The block then
// gives N bins, k = 0..N-1, each shown for one cycle with bin_valid high; the
// receiver must take every bin as it appears. For each bin the running twiddle
// goes through the one shared complex multiplier, which registers a product and
// then rounds it while the sample is accumulated, for every sample in turn; the
// bin twiddle then steps on through the same multiplier. No new block is taken
// until the last bin is out, as start is ignored while busy. A sample that is
// not last leaves the block idle and ready for the next one. Write root_real and
// root_imag (Q2.30 e^(-i2pi/N)) only while the block is idle.
module direct_dft_real_input_core
    import ddft_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int CNT_W = $clog2(MAX_POINTS + 1),
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // sample channel
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_sample,
    // bin channel
    output logic                       bin_valid,
    output logic [IDX_W-1:0]           bin_index,
    output logic signed [OUT_W-1:0]    bin_real,
    output logic signed [OUT_W-1:0]    bin_imag,
    output logic                       last_bin,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] t_reg, t_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic signed [TW_W-1:0] rt_re_reg, rt_im_reg, rt_re_next, rt_im_next;
    logic signed [TW_W-1:0] bt_re_reg, bt_im_reg, bt_re_next, bt_im_next;
    logic signed [TW_W-1:0] root_real_reg, root_imag_reg;
    logic signed [TW_W-1:0] root_real_next, root_imag_next;
    logic signed [TW_W-1:0] root_re_c, root_im_c;

    logic                    bin_valid_reg, bin_valid_next;
    logic [IDX_W-1:0]        bin_index_reg, bin_index_next;
    logic signed [OUT_W-1:0] bin_real_reg, bin_real_next;
    logic signed [OUT_W-1:0] bin_imag_reg, bin_imag_next;
    logic                    last_bin_reg, last_bin_next;

    logic accept, trigger, t_last, k_last, cfg_wr;

    cell_ctrl_t cell_ctrl;
    acc_ctrl_t  acc_ctrl;
    logic       cmul_en, cmul_bin_sel, out_latch, rt_load, bt_load, run_init;

    logic signed [TW_W-1:0] cm_a_re, cm_a_im, cm_b_re, cm_b_im;
    logic signed [TW_W-1:0] cm_p_re, cm_p_im;
    logic signed [OUT_W-1:0] fin_re, fin_im;

    logic signed [SAMPLE_W-1:0] cell_q [MAX_POINTS];
    logic [MAX_POINTS-1:0]      cell_sel, cell_wrap;

    // handshake and loop ends
    assign accept  = start && !busy;
    assign trigger = last_sample || (count_reg + CNT_W'(1) == CNT_W'(MAX_POINTS));
    assign t_last  = (CNT_W'(t_reg) + CNT_W'(1) == n_reg);
    assign k_last  = (CNT_W'(k_reg) + CNT_W'(1) == n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && trigger)
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = t_last ? ST_BMUL : ST_MUL;
            ST_BMUL: state_next = ST_BADD;
            ST_BADD: state_next = k_last ? ST_IDLE : ST_MUL;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy               = 1'b1;
        cell_ctrl.write_en = 1'b0;
        cell_ctrl.rotate_en = 1'b0;
        acc_ctrl.clear     = 1'b0;
        acc_ctrl.mul_en    = 1'b0;
        acc_ctrl.add_en    = 1'b0;
        cmul_en            = 1'b0;
        cmul_bin_sel       = 1'b0;
        out_latch          = 1'b0;
        rt_load            = 1'b0;
        bt_load            = 1'b0;
        run_init           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy               = 1'b0;
                cell_ctrl.write_en = accept;
                run_init           = accept && trigger;
                acc_ctrl.clear     = accept && trigger;
            end
            ST_MUL:
            begin
                cmul_en         = 1'b1;
                acc_ctrl.mul_en = 1'b1;
            end
            ST_ADD:
            begin
                acc_ctrl.add_en     = 1'b1;
                cell_ctrl.rotate_en = 1'b1;
                rt_load             = 1'b1;
            end
            ST_BMUL:
            begin
                cmul_en      = 1'b1;
                cmul_bin_sel = 1'b1;
                out_latch    = 1'b1;
            end
            ST_BADD:
            begin
                bt_load        = 1'b1;
                acc_ctrl.clear = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    // root registers are clamped to [-1.0, 1.0] on use
    assign root_re_c = clamp_q(PROD_W'(root_real_reg));
    assign root_im_c = clamp_q(PROD_W'(root_imag_reg));

    // register port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (reg_idx_t'(paddr[2]) == REG_ROOT_IMAG) ? root_imag_reg : root_real_reg;

    always_comb
    begin
        root_real_next = root_real_reg;
        root_imag_next = root_imag_reg;
        if (cfg_wr)
        begin
            if (reg_idx_t'(paddr[2]) == REG_ROOT_IMAG)
                root_imag_next = pwdata;
            else
                root_real_next = pwdata;
        end
    end

    // shared complex multiplier operands
    assign cm_a_re = cmul_bin_sel ? bt_re_reg : rt_re_reg;
    assign cm_a_im = cmul_bin_sel ? bt_im_reg : rt_im_reg;
    assign cm_b_re = cmul_bin_sel ? root_re_c : bt_re_reg;
    assign cm_b_im = cmul_bin_sel ? root_im_c : bt_im_reg;

    ddft_cmul u_cmul (
        .clk  (clk),
        .en   (cmul_en),
        .a_re (cm_a_re),
        .a_im (cm_a_im),
        .b_re (cm_b_re),
        .b_im (cm_b_im),
        .p_re (cm_p_re),
        .p_im (cm_p_im)
    );

    ddft_acc u_acc (
        .clk    (clk),
        .ctrl   (acc_ctrl),
        .sample (cell_q[0]),
        .tw_re  (rt_re_reg),
        .tw_im  (rt_im_reg),
        .fin_re (fin_re),
        .fin_im (fin_im)
    );

    // row of sample cells, rotating toward cell 0 and wrapping at cell N-1
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        assign cell_sel[i]  = (count_reg == CNT_W'(i));
        assign cell_wrap[i] = (n_reg == CNT_W'(i + 1));

        ddft_cell u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .sel      (cell_sel[i]),
            .wrap     (cell_wrap[i]),
            .din_new  (sample),
            .din_next (cell_q[(i + 1 < MAX_POINTS) ? i + 1 : 0]),
            .din_head (cell_q[0]),
            .dout     (cell_q[i])
        );
    end

    // counters and twiddles
    always_comb
    begin
        count_next = count_reg;
        n_next     = n_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        rt_re_next = rt_re_reg;
        rt_im_next = rt_im_reg;
        bt_re_next = bt_re_reg;
        bt_im_next = bt_im_reg;
        if (cell_ctrl.write_en)
            count_next = trigger ? '0 : count_reg + CNT_W'(1);
        if (run_init)
        begin
            n_next     = count_reg + CNT_W'(1);
            t_next     = '0;
            k_next     = '0;
            rt_re_next = Q_ONE;
            rt_im_next = '0;
            bt_re_next = Q_ONE;
            bt_im_next = '0;
        end
        if (rt_load)
        begin
            rt_re_next = cm_p_re;
            rt_im_next = cm_p_im;
            t_next     = t_last ? '0 : t_reg + IDX_W'(1);
        end
        if (bt_load)
        begin
            bt_re_next = cm_p_re;
            bt_im_next = cm_p_im;
            rt_re_next = Q_ONE;
            rt_im_next = '0;
            k_next     = k_last ? '0 : k_reg + IDX_W'(1);
        end
    end

    // bin output register, bin_valid high for a single cycle per bin
    always_comb
    begin
        bin_valid_next = out_latch;
        bin_index_next = bin_index_reg;
        bin_real_next  = bin_real_reg;
        bin_imag_next  = bin_imag_reg;
        last_bin_next  = last_bin_reg;
        if (out_latch)
        begin
            bin_index_next = k_reg;
            bin_real_next  = fin_re;
            bin_imag_next  = fin_im;
            last_bin_next  = k_last;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            t_reg         <= '0;
            k_reg         <= '0;
            bin_valid_reg <= 1'b0;
            root_real_reg <= Q_ONE;
            root_imag_reg <= '0;
            rt_re_reg     <= Q_ONE;
            rt_im_reg     <= '0;
            bt_re_reg     <= Q_ONE;
            bt_im_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            t_reg         <= t_next;
            k_reg         <= k_next;
            bin_valid_reg <= bin_valid_next;
            root_real_reg <= root_real_next;
            root_imag_reg <= root_imag_next;
            rt_re_reg     <= rt_re_next;
            rt_im_reg     <= rt_im_next;
            bt_re_reg     <= bt_re_next;
            bt_im_reg     <= bt_im_next;
        end
    end

    // bin payload
    always_ff @(posedge clk)
    begin
        bin_index_reg <= bin_index_next;
        bin_real_reg  <= bin_real_next;
        bin_imag_reg  <= bin_imag_next;
        last_bin_reg  <= last_bin_next;
    end

    assign bin_valid = bin_valid_reg;
    assign bin_index = bin_index_reg;
    assign bin_real  = bin_real_reg;
    assign bin_imag  = bin_imag_reg;
    assign last_bin  = last_bin_reg;

endmodule

// ===== rtl/ddft_chk.sv =====
module ddft_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_sample,
    input logic bin_valid,
    input logic last_bin,
    input logic pready
);

    // a bin beat only appears while a transform runs
    assert property (@(posedge clk) disable iff (!rst_n) bin_valid |-> busy)
        else $error("bin beat while idle");

    // bin beats are single-cycle strobes, never back to back
    assert property (@(posedge clk) disable iff (!rst_n) bin_valid |=> !bin_valid)
        else $error("bin strobe held for two cycles");

    // a last sample always starts a transform
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_sample) |=> busy)
        else $error("last sample did not start a transform");

    // the final bin ends the transform
    assert property (@(posedge clk) disable iff (!rst_n)
        (bin_valid && last_bin) |=> !busy)
        else $error("still busy after final bin");

    // register port never waits
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind direct_dft_real_input_core ddft_chk u_ddft_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .last_sample (last_sample),
    .bin_valid   (bin_valid),
    .last_bin    (last_bin),
    .pready      (pready)
);
